FILE: hdl/first_fit_power_of_two_allocator_defines.svh
// ----------------------------------------------------------------------------
// first_fit_power_of_two_allocator_defines
// Assertion macros used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_POWER_OF_TWO_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_POWER_OF_TWO_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FFPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types, codes and helpers shared by the first-fit allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 16;
    localparam int LOG_W     = 5;
    // request_size plus header always fits in this many bits
    localparam int SUM_W     = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [LOG_W-1:0] MIN_LOG = 5'd4;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_MEM    = 2'd1,
        ST_IGNORED   = 2'd2,
        ST_LIST_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] user_address;
    } t_request;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        t_status           status;
    } t_result;

    // command from the sequencer to the free list
    typedef struct packed {
        logic              scan;
        logic              push;
        logic [LOG_W-1:0]  need_log;
        logic [ADDR_W-1:0] push_block;
        logic [LOG_W-1:0]  push_log;
    } t_fl_cmd;

    // free list status back to the sequencer
    typedef struct packed {
        logic              done;
        logic              hit;
        logic              full;
        logic [ADDR_W-1:0] block;
    } t_fl_sts;

    // number of bits needed to hold v (position of highest one, plus one)
    function automatic logic [LOG_W-1:0] bit_length(input logic [SUM_W-1:0] v);
        logic [LOG_W-1:0] n;
        n = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (v[i]) begin
                n = LOG_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/first_fit_power_of_two_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_power_of_two_allocator
// Heap allocator: first-fit reuse of freed power-of-two blocks, bump
// allocation from a break pointer otherwise.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low. The reply is
// shown for exactly one cycle with o_strobe and cannot be held off; busy
// stays high until then, except for the immediate replies below, for which it
// never rises. Requests are handled one at a time. A zero-size allocate or a
// null free answers on the next cycle. Other frees go through a range check
// with block-size RAM read, then answer if rejected (out of range or list
// full) or else push the block. An allocate scans the free list one entry per
// cycle from the newest. A hit on the newest entry answers without compaction;
// a hit below e newer entries first moves those e entries one slot down
// through the single list RAM port pair, then drains. A miss over all entries
// falls back to a bump from the break pointer. Writing heap_start also resets
// the break.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_power_of_two_allocator #(
    parameter int FREE_SLOTS   = 16,
    parameter int HEAP_UNITS   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire ffpa_pkg::t_request                  i_request,
    output logic                                     o_strobe,
    output ffpa_pkg::t_result                        o_result,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ffpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ffpa_pkg::ADDR_W-1:0]         i_cfg_data
);

`include "first_fit_power_of_two_allocator_defines.svh"

    localparam int AW     = ffpa_pkg::ADDR_W;
    localparam int LW     = ffpa_pkg::LOG_W;
    localparam int HA_W   = (HEAP_UNITS > 1) ? $clog2(HEAP_UNITS) : 1;
    localparam int UNIT_W = $clog2(HEAP_UNITS + 1);
    localparam logic [AW:0] SPAN = (AW + 1)'(HEAP_UNITS) << 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_CHK,
        S_FREE_RD,
        S_SCAN,
        S_BUMP
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_heap_start;
    logic [AW-1:0]         r_heap_end;
    logic [AW:0]           r_cap;
    logic [AW-1:0]         r_bp;
    logic [UNIT_W-1:0]     r_unit;
    logic [LW-1:0]         r_lg;
    logic [AW-1:0]         r_block;
    logic [AW:0]           r_newbrk;
    logic                  r_strobe;
    ffpa_pkg::t_result     r_result;

    logic                  w_accept;
    logic [ffpa_pkg::SUM_W-1:0] w_sum;
    logic [LW-1:0]         w_bitlen;
    logic [LW-1:0]         w_lg;
    logic [AW:0]           w_size;
    logic [AW:0]           w_diff;
    logic                  w_out_of_range;
    logic                  w_bump_fail;
    logic                  w_sz_we;
    logic [LW-1:0]         w_sz_rdata;
    ffpa_pkg::t_fl_cmd     w_fl_cmd;
    ffpa_pkg::t_fl_sts     w_fl_sts;

    assign w_accept = start && !busy;

    // rounded block size: 2^bitlen(request + header), at least 16 bytes
    assign w_sum    = ffpa_pkg::SUM_W'(i_request.request_size)
                    + ffpa_pkg::SUM_W'(HEADER_BYTES);
    assign w_bitlen = ffpa_pkg::bit_length(w_sum);
    assign w_lg     = (w_bitlen < ffpa_pkg::MIN_LOG) ? ffpa_pkg::MIN_LOG : w_bitlen;
    assign w_size   = (AW + 1)'(1) << r_lg;

    // free range check: borrow means below heap start
    assign w_diff         = {1'b0, r_block} - {1'b0, r_heap_start};
    assign w_out_of_range = w_diff[AW] || (w_diff[AW-1:4] >= (AW - 4)'(HEAP_UNITS));

    // bump limit against heap end and the managed span
    assign w_bump_fail = (r_newbrk >= {1'b0, r_heap_end}) || (r_newbrk > r_cap);

    // free list commands
    assign w_fl_cmd.scan       = w_accept && (i_request.op == ffpa_pkg::OP_ALLOC)
                               && (i_request.request_size != '0);
    assign w_fl_cmd.push       = (r_state == S_FREE_RD);
    assign w_fl_cmd.need_log   = w_lg;
    assign w_fl_cmd.push_block = r_block;
    assign w_fl_cmd.push_log   = w_sz_rdata;

    ffpa_free_list #(
        .FREE_SLOTS (FREE_SLOTS)
    ) u_free_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_fl_cmd),
        .o_sts   (w_fl_sts)
    );

    // block size log per 16-byte heap unit, written on a successful bump
    assign w_sz_we = (r_state == S_BUMP) && !w_bump_fail
                   && (r_unit < UNIT_W'(HEAP_UNITS));

    ffpa_ram #(
        .WIDTH  (LW),
        .DEPTH  (HEAP_UNITS),
        .ADDR_W (HA_W)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_sz_we),
        .i_waddr (r_unit[HA_W-1:0]),
        .i_wdata (r_lg),
        .i_raddr (w_diff[HA_W+3:4]),
        .o_rdata (w_sz_rdata)
    );

    // request sequencer, break pointer and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_heap_start <= '0;
            r_heap_end   <= AW'(65536);
            r_cap        <= SPAN;
            r_bp         <= '0;
            r_unit       <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_request.op == ffpa_pkg::OP_ALLOC) begin
                            if (i_request.request_size == '0) begin
                                r_strobe <= 1'b1;
                                r_result <= '{result_address: '0,
                                              status: ffpa_pkg::ST_IGNORED};
                            end else begin
                                r_lg    <= w_lg;
                                r_state <= S_SCAN;
                            end
                        end else if (i_request.user_address == '0) begin
                            r_strobe <= 1'b1;
                            r_result <= '{result_address: '0,
                                          status: ffpa_pkg::ST_IGNORED};
                        end else begin
                            r_block <= i_request.user_address - AW'(HEADER_BYTES);
                            r_state <= S_FREE_CHK;
                        end
                    end
                end
                S_FREE_CHK: begin
                    if (w_out_of_range) begin
                        r_strobe <= 1'b1;
                        r_result <= '{result_address: '0,
                                      status: ffpa_pkg::ST_IGNORED};
                        r_state  <= S_IDLE;
                    end else if (w_fl_sts.full) begin
                        r_strobe <= 1'b1;
                        r_result <= '{result_address: '0,
                                      status: ffpa_pkg::ST_LIST_FULL};
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_FREE_RD;
                    end
                end
                S_FREE_RD: begin
                    // size read is back; the list push happens this cycle
                    r_strobe <= 1'b1;
                    r_result <= '{result_address: '0, status: ffpa_pkg::ST_OK};
                    r_state  <= S_IDLE;
                end
                S_SCAN: begin
                    if (w_fl_sts.done) begin
                        if (w_fl_sts.hit) begin
                            r_strobe <= 1'b1;
                            r_result <= '{result_address: w_fl_sts.block
                                                          + AW'(HEADER_BYTES),
                                          status: ffpa_pkg::ST_OK};
                            r_state  <= S_IDLE;
                        end else begin
                            r_newbrk <= {1'b0, r_bp} + w_size;
                            r_state  <= S_BUMP;
                        end
                    end
                end
                S_BUMP: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                    if (w_bump_fail) begin
                        r_result <= '{result_address: '0,
                                      status: ffpa_pkg::ST_NO_MEM};
                    end else begin
                        r_result <= '{result_address: r_bp + AW'(HEADER_BYTES),
                                      status: ffpa_pkg::ST_OK};
                        r_bp     <= r_newbrk[AW-1:0];
                        r_unit   <= r_unit + UNIT_W'(w_size >> 4);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // register writes must arrive only while idle; the block does not enforce this
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ffpa_pkg::CFG_HEAP_START: begin
                        r_heap_start <= i_cfg_data;
                        r_bp         <= i_cfg_data;
                        r_unit       <= '0;
                        r_cap        <= {1'b0, i_cfg_data} + SPAN;
                    end
                    ffpa_pkg::CFG_HEAP_END: begin
                        r_heap_end <= i_cfg_data;
                    end
                    default: begin
                        r_heap_end <= r_heap_end;
                    end
                endcase
            end
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    // checks
    `FFPA_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, w_accept, busy || o_strobe, "stalled")
    `FFPA_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "reply while busy")
    `FFPA_ASSERT_NOW(a_fl_done_scan, i_clk, i_rst_n, w_fl_sts.done, r_state == S_SCAN, "stray done")
    `FFPA_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, w_fl_cmd.push, !w_fl_sts.full, "full push")

endmodule

`default_nettype wire

FILE: hdl/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/ffpa_free_list.sv
// ----------------------------------------------------------------------------
// ffpa_free_list
// Freed-block list held in RAM: push at the tail, first-fit scan from the
// tail toward the head, and compaction of the entries above a removed one.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_free_list #(
    parameter int FREE_SLOTS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ffpa_pkg::t_fl_cmd i_cmd,
    output ffpa_pkg::t_fl_sts     o_sts
);

    localparam int CNT_W = $clog2(FREE_SLOTS + 1);
    localparam int AW    = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int ENT_W = ffpa_pkg::ADDR_W + ffpa_pkg::LOG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DRAIN
    } t_state;

    t_state                       r_state;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_slot;
    logic [ffpa_pkg::LOG_W-1:0]   r_need;
    logic                         r_wb_valid;
    logic [CNT_W-1:0]             r_wb_dst;
    logic                         r_done;
    logic                         r_hit;
    logic [ffpa_pkg::ADDR_W-1:0]  r_block;

    logic                         w_we;
    logic [CNT_W-1:0]             w_waddr;
    logic [ENT_W-1:0]             w_wdata;
    logic [CNT_W-1:0]             w_raddr;
    logic [ENT_W-1:0]             w_rdata;
    logic [ffpa_pkg::ADDR_W-1:0]  w_rd_block;
    logic [ffpa_pkg::LOG_W-1:0]   w_rd_log;
    logic                         w_last;

    assign w_rd_block = w_rdata[ENT_W-1:ffpa_pkg::LOG_W];
    assign w_rd_log   = w_rdata[ffpa_pkg::LOG_W-1:0];
    // current slot is the newest entry
    assign w_last     = ((r_slot + CNT_W'(1)) == r_count);

    // read address: newest entry on scan start, one below while scanning,
    // source entry while compacting
    always_comb begin
        case (r_state)
            S_IDLE:  w_raddr = r_count - CNT_W'(1);
            S_SCAN:  w_raddr = (r_slot == '0) ? '0 : (r_slot - CNT_W'(1));
            S_SHIFT: w_raddr = r_slot;
            default: w_raddr = '0;
        endcase
    end

    // write port: compaction write-back first, else push at the tail
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count;
        w_wdata = {i_cmd.push_block, i_cmd.push_log};
        if (r_wb_valid) begin
            w_we    = 1'b1;
            w_waddr = r_wb_dst;
            w_wdata = w_rdata;
        end else if (r_state == S_IDLE && i_cmd.push) begin
            w_we = 1'b1;
        end
    end

    ffpa_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (FREE_SLOTS),
        .ADDR_W (AW)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // list sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_wb_valid <= 1'b0;
            r_done     <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_done     <= 1'b0;
            r_wb_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.push) begin
                        r_count <= r_count + CNT_W'(1);
                    end else if (i_cmd.scan) begin
                        r_need <= i_cmd.need_log;
                        if (r_count == '0) begin
                            r_done <= 1'b1;
                            r_hit  <= 1'b0;
                        end else begin
                            r_slot  <= r_count - CNT_W'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_rd_log >= r_need) begin
                        r_block <= w_rd_block;
                        if (w_last) begin
                            // newest entry taken, nothing to compact
                            r_count <= r_count - CNT_W'(1);
                            r_done  <= 1'b1;
                            r_hit   <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= r_slot + CNT_W'(1);
                            r_state <= S_SHIFT;
                        end
                    end else if (r_slot == '0) begin
                        r_done  <= 1'b1;
                        r_hit   <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_slot <= r_slot - CNT_W'(1);
                    end
                end
                S_SHIFT: begin
                    // entry read now lands one slot lower next cycle
                    r_wb_valid <= 1'b1;
                    r_wb_dst   <= r_slot - CNT_W'(1);
                    if (w_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_slot <= r_slot + CNT_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_count <= r_count - CNT_W'(1);
                    r_done  <= 1'b1;
                    r_hit   <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sts.done  = r_done;
    assign o_sts.hit   = r_hit;
    assign o_sts.full  = (r_count == CNT_W'(FREE_SLOTS));
    assign o_sts.block = r_block;

endmodule

`default_nettype wire
